// ----- design/volume_neighbourhood_max_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the volume neighbourhood maximum unit
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VOLUME_NEIGHBOURHOOD_MAX_UNIT_DEFINES_SVH
`define VOLUME_NEIGHBOURHOOD_MAX_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VNM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vnm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VNM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vnm: next-cycle check failed");

`endif

// ----- design/vnm_pkg.sv -----
// ----------------------------------------------------------------------------
// vnm_pkg
// Types and constants of the volume neighbourhood maximum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vnm_pkg;

  localparam int unsigned POS_W  = 5;
  localparam int unsigned SIZE_W = 6;
  localparam int unsigned VOX_W  = 8;
  localparam int unsigned IDX_W  = 2;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [VOX_W-1:0]  vox_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Action codes of an input item.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes.
  localparam idx_t REG_SIZE_X = 2'd0;
  localparam idx_t REG_SIZE_Y = 2'd1;
  localparam idx_t REG_SIZE_Z = 2'd2;

  // Neighbour step along one axis: 0, 1, 2 mean offsets -1, 0, +1.
  typedef logic [1:0] step_t;
  localparam step_t STEP_LO  = 2'd0;
  localparam step_t STEP_MID = 2'd1;
  localparam step_t STEP_HI  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ----- design/vnm_if.sv -----
// ----------------------------------------------------------------------------
// vnm_in_if / vnm_out_if
// Valid/ready channels for voxel items and neighbourhood maximum results.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnm_in_if;
  logic          valid;
  logic          ready;
  logic          action;
  vnm_pkg::pos_t pos_x;
  vnm_pkg::pos_t pos_y;
  vnm_pkg::pos_t pos_z;
  vnm_pkg::vox_t voxel_value;

  modport source (output valid, action, pos_x, pos_y, pos_z, voxel_value, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, voxel_value, output ready);
endinterface

interface vnm_out_if;
  logic          valid;
  logic          ready;
  vnm_pkg::vox_t max_value;

  modport source (output valid, max_value, input ready);
  modport sink   (input valid, max_value, output ready);
endinterface

`default_nettype wire

// ----- design/vnm_ram.sv -----
// ----------------------------------------------------------------------------
// vnm_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vnm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/volume_neighbourhood_max_unit.sv -----
// ----------------------------------------------------------------------------
// volume_neighbourhood_max_unit
// Stores a volume of 8-bit voxels and answers 3x3x3 neighbourhood maximum
// queries with edge replication, one stored voxel read per cycle.
// ----------------------------------------------------------------------------
//   channel  | dir | carries                                   | results
//   vox_i    | in  | action, pos_x, pos_y, pos_z, voxel_value  | -
//   res_o    | out | max_value                                 | one per query
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i           | -
//
// A write item is taken and stored at once; ready stays high.
// A query makes 27 reads of the single memory port, one per cycle, then
// folds in the last read in a finishing state that registers the result.
// A finished result waits in the output register; a further query may run
// meanwhile and holds its final fold until the register is free.
// Reset clears the control state and the size registers (32 each); the
// voxel store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_neighbourhood_max_unit #(
  parameter int unsigned MAX_DIM = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire vnm_pkg::idx_t  cfg_idx_i,
  input  wire vnm_pkg::size_t cfg_data_i,
  vnm_in_if.sink              vox_i,
  vnm_out_if.source           res_o
);

  import vnm_pkg::*;

  `include "volume_neighbourhood_max_unit_defines.svh"

  localparam int unsigned AW    = $clog2(MAX_DIM);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;

  // Extent with zero read as one and saturation at the store pitch.
  function automatic size_t eff_extent(size_t s);
    size_t e;
    if (s == '0) begin
      e = size_t'(1);
    end else if (int'(s) > int'(MAX_DIM)) begin
      e = size_t'(MAX_DIM);
    end else begin
      e = s;
    end
    return e;
  endfunction

  function automatic size_t clamp_axis(pos_t c, step_t st, size_t ext);
    size_t v;
    size_t hi;
    hi = ext - size_t'(1);
    case (st)
      STEP_LO:  v = (c == '0) ? '0 : size_t'(c) - size_t'(1);
      STEP_HI:  v = size_t'(c) + size_t'(1);
      default:  v = size_t'(c);
    endcase
    return (v > hi) ? hi : v;
  endfunction

  state_e state_q, state_d;
  size_t  size_x_q, size_y_q, size_z_q;
  pos_t   px_q, py_q, pz_q;
  step_t  ix_q, iy_q, iz_q, ix_d, iy_d, iz_d;
  logic   rd_pend_q, rd_pend_d;
  vox_t   acc_q, acc_d;
  logic   out_valid_q, out_valid_d;
  vox_t   out_value_q, out_value_d;

  logic   in_acc, wr_en, rd_en, in_range, last_step, slot_free;
  vox_t   rdata, fold;
  size_t  cx, cy, cz;
  logic [3*AW-1:0] ram_addr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= size_t'(32);
      size_y_q <= size_t'(32);
      size_z_q <= size_t'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_X: size_x_q <= cfg_data_i;
        REG_SIZE_Y: size_y_q <= cfg_data_i;
        REG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vox_i.ready = (state_q == ST_IDLE);
  assign in_acc      = vox_i.valid && vox_i.ready;

  assign in_range = (int'(vox_i.pos_x) < int'(MAX_DIM)) &&
                    (int'(vox_i.pos_y) < int'(MAX_DIM)) &&
                    (int'(vox_i.pos_z) < int'(MAX_DIM));
  assign wr_en    = in_acc && (vox_i.action == ACT_WRITE) && in_range;
  assign rd_en    = (state_q == ST_SCAN);

  assign cx = clamp_axis(px_q, ix_q, eff_extent(size_x_q));
  assign cy = clamp_axis(py_q, iy_q, eff_extent(size_y_q));
  assign cz = clamp_axis(pz_q, iz_q, eff_extent(size_z_q));

  // Pitch is a power of two, so the address is the coordinates side by side.
  always_comb begin
    if (rd_en) begin
      ram_addr = {AW'(cz), AW'(cy), AW'(cx)};
    end else begin
      ram_addr = {AW'(vox_i.pos_z), AW'(vox_i.pos_y), AW'(vox_i.pos_x)};
    end
  end

  vnm_ram #(
    .WIDTH (VOX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .re_i    (rd_en),
    .addr_i  (ram_addr),
    .wdata_i (vox_i.voxel_value),
    .rdata_o (rdata)
  );

  // The one compare unit, shared by every neighbour in turn.
  assign fold      = (rdata > acc_q) ? rdata : acc_q;
  assign last_step = (ix_q == STEP_HI) && (iy_q == STEP_HI) && (iz_q == STEP_HI);
  assign slot_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    ix_d        = ix_q;
    iy_d        = iy_q;
    iz_d        = iz_q;
    rd_pend_d   = rd_pend_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_value_d = out_value_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (vox_i.action == ACT_QUERY)) begin
          state_d   = ST_SCAN;
          ix_d      = STEP_LO;
          iy_d      = STEP_LO;
          iz_d      = STEP_LO;
          rd_pend_d = 1'b0;
          acc_d     = '0;
        end
      end
      ST_SCAN: begin
        rd_pend_d = 1'b1;
        if (rd_pend_q) begin
          acc_d = fold;
        end
        if (last_step) begin
          state_d = ST_FIN;
        end else if (ix_q != STEP_HI) begin
          ix_d = ix_q + step_t'(1);
        end else begin
          ix_d = STEP_LO;
          if (iy_q != STEP_HI) begin
            iy_d = iy_q + step_t'(1);
          end else begin
            iy_d = STEP_LO;
            iz_d = iz_q + step_t'(1);
          end
        end
      end
      ST_FIN: begin
        // The last read data holds, so waiting here is safe.
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_value_d = fold;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ix_q        <= STEP_LO;
      iy_q        <= STEP_LO;
      iz_q        <= STEP_LO;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ix_q        <= ix_d;
      iy_q        <= iy_d;
      iz_q        <= iz_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    out_value_q <= out_value_d;
    if (in_acc) begin
      px_q <= vox_i.pos_x;
      py_q <= vox_i.pos_y;
      pz_q <= vox_i.pos_z;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.max_value = out_value_q;

  `VNM_ASSERT_NEXT(a_query_starts_scan, clk_i, rst_ni,
                   in_acc && (vox_i.action == ACT_QUERY),
                   (state_q == ST_SCAN) && !rd_pend_q && (ix_q == STEP_LO))
  `VNM_ASSERT_NEXT(a_write_stays_idle, clk_i, rst_ni,
                   in_acc && (vox_i.action == ACT_WRITE),
                   (state_q == ST_IDLE) && vox_i.ready)
  `VNM_ASSERT_NOW(a_steps_in_range, clk_i, rst_ni,
                  state_q == ST_SCAN,
                  (ix_q <= STEP_HI) && (iy_q <= STEP_HI) && (iz_q <= STEP_HI))
  `VNM_ASSERT_NEXT(a_fin_delivers, clk_i, rst_ni,
                   (state_q == ST_FIN) && slot_free,
                   out_valid_q && (state_q == ST_IDLE))
  `VNM_ASSERT_NOW(a_no_write_while_busy, clk_i, rst_ni,
                  state_q != ST_IDLE,
                  !wr_en)

endmodule

`default_nettype wire

// ----- bench/volume_neighbourhood_max_unit_tb.sv -----
// ----------------------------------------------------------------------------
// volume_neighbourhood_max_unit_tb
// Self-checking bench for the 3x3x3 neighbourhood maximum unit. A table of
// directed items runs first: zero and oversized extents, centres outside
// the volume, value extremes and an unknown register index. Random phases
// follow, with fresh extents in each. Every query reads only voxels that the
// bench has written. A mirror of the store predicts each query's maximum,
// and results are compared in order while both sides idle at random.
// ----------------------------------------------------------------------------

module volume_neighbourhood_max_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vnm_pkg::*;

  localparam int unsigned VOL_DIM      = 32;
  localparam int unsigned ADDR_W       = 3 * POS_W;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned PHASE_ITEMS  = 90;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // No register sits at this index; a write there must change nothing.
  localparam idx_t REG_UNUSED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    idx_t      reg_idx;
    size_t     reg_data;
    logic      action;
    pos_t      x;
    pos_t      y;
    pos_t      z;
    vox_t      value;
    logic      has_exp;
    vox_t      exp_max;
  } stim_row_t;

  localparam int unsigned N_ROWS = 24;

  stim_row_t directed_rows [N_ROWS] = '{
    // Extent zero behaves as one voxel: every neighbour folds onto the origin.
    '{ROW_CFG,  REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 8'h00},
    '{ROW_CFG,  REG_SIZE_Y, 6'd0,  ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 8'h00},
    '{ROW_CFG,  REG_SIZE_Z, 6'd0,  ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'hFF, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_QUERY, 5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 8'hFF},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_QUERY, 5'd31, 5'd31, 5'd31, 8'h00, 1'b1, 8'hFF},
    // Stored although it lies outside the current extent.
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd31, 5'd31, 5'd31, 8'h5A, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_QUERY, 5'd17, 5'd5,  5'd30, 8'hFF, 1'b1, 8'h00},
    '{ROW_CFG,  REG_UNUSED, 6'h3F, ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_QUERY, 5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 8'h00},
    // Extents above the store size saturate to the full store.
    '{ROW_CFG,  REG_SIZE_X, 6'd63, ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 8'h00},
    '{ROW_CFG,  REG_SIZE_Y, 6'd40, ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 8'h00},
    '{ROW_CFG,  REG_SIZE_Z, 6'd33, ACT_WRITE, 5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd30, 5'd30, 5'd30, 8'h11, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd31, 5'd30, 5'd30, 8'h22, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd30, 5'd31, 5'd30, 8'h33, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd31, 5'd31, 5'd30, 8'h44, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd30, 5'd30, 5'd31, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd31, 5'd30, 5'd31, 8'h55, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd30, 5'd31, 5'd31, 8'h01, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_QUERY, 5'd31, 5'd31, 5'd31, 8'h00, 1'b1, 8'h5A},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_WRITE, 5'd30, 5'd31, 5'd31, 8'hFF, 1'b0, 8'h00},
    '{ROW_ITEM, REG_SIZE_X, 6'd0,  ACT_QUERY, 5'd31, 5'd31, 5'd31, 8'h00, 1'b1, 8'hFF}
  };

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i;
  idx_t  cfg_idx_i;
  size_t cfg_data_i;

  vnm_in_if  vox_ch ();
  vnm_out_if res_ch ();

  volume_neighbourhood_max_unit #(
    .MAX_DIM (VOL_DIM)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .vox_i      (vox_ch),
    .res_o      (res_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the block: voxel store, which entries hold data, and extents.
  vox_t  volume_mirror [1 << ADDR_W];
  bit    written_mask  [1 << ADDR_W];
  size_t size_x_reg = 6'd32;
  size_t size_y_reg = 6'd32;
  size_t size_z_reg = 6'd32;

  vox_t expected_max_q [$];
  int   error_count = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  bit   send_calm = 1'b0;
  bit   recv_calm = 1'b0;

  function automatic int extent(size_t s);
    if (s == '0) return 1;
    if (s > VOL_DIM) return VOL_DIM;
    return int'(s);
  endfunction

  function automatic pos_t clamp_pos(int c, int ext);
    int v;
    v = c;
    if (v < 0) v = 0;
    if (v > ext - 1) v = ext - 1;
    return pos_t'(v);
  endfunction

  // Store address of neighbour k (0..26) around a centre, after edge clamping.
  function automatic logic [ADDR_W-1:0] neighbour_addr(pos_t cx, pos_t cy, pos_t cz, int k);
    pos_t ax, ay, az;
    ax = clamp_pos(int'(cx) + (k % 3) - 1, extent(size_x_reg));
    ay = clamp_pos(int'(cy) + ((k / 3) % 3) - 1, extent(size_y_reg));
    az = clamp_pos(int'(cz) + (k / 9) - 1, extent(size_z_reg));
    return {az, ay, ax};
  endfunction

  function automatic vox_t neighbourhood_max(pos_t cx, pos_t cy, pos_t cz);
    vox_t best;
    vox_t v;
    best = '0;
    for (int k = 0; k < 27; k++) begin
      v = volume_mirror[neighbour_addr(cx, cy, cz, k)];
      if (v > best) best = v;
    end
    return best;
  endfunction

  function automatic pos_t pick_pos(int ext);
    if ($urandom_range(0, 9) < 7) return pos_t'($urandom_range(0, ext - 1));
    return pos_t'($urandom_range(0, VOL_DIM - 1));
  endfunction

  function automatic vox_t pick_value();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return vox_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly small extents keep neighbourhood preparation cheap.
  function automatic size_t pick_extent();
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return size_t'($urandom_range(VOL_DIM + 1, 63));
      2: return 6'd32;
      3: return 6'd1;
      default: return size_t'($urandom_range(2, 6));
    endcase
  endfunction

  task automatic write_reg(idx_t idx, size_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SIZE_X: size_x_reg = data;
      REG_SIZE_Y: size_y_reg = data;
      REG_SIZE_Z: size_z_reg = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offers one item and records what it should produce once it is taken.
  task automatic send_item(logic action, pos_t x, pos_t y, pos_t z, vox_t value,
                           logic has_exp, vox_t exp_max);
    int gap;
    vox_t predicted;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    if (gap > 0) begin
      vox_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vox_ch.valid       <= 1'b1;
    vox_ch.action      <= action;
    vox_ch.pos_x       <= x;
    vox_ch.pos_y       <= y;
    vox_ch.pos_z       <= z;
    vox_ch.voxel_value <= value;
    do @(posedge clk_i); while (vox_ch.ready !== 1'b1);
    items_sent++;
    if (action == ACT_WRITE) begin
      volume_mirror[{z, y, x}] = value;
      written_mask[{z, y, x}]  = 1'b1;
    end else begin
      predicted = has_exp ? exp_max : neighbourhood_max(x, y, z);
      expected_max_q = {expected_max_q, predicted};
    end
  endtask

  // Writes whatever the query would read that holds no data yet, then queries.
  task automatic query_prepared(pos_t x, pos_t y, pos_t z);
    logic [ADDR_W-1:0] a;
    for (int k = 0; k < 27; k++) begin
      a = neighbour_addr(x, y, z, k);
      if (!written_mask[a])
        send_item(ACT_WRITE, a[POS_W-1:0], a[2*POS_W-1:POS_W], a[ADDR_W-1:2*POS_W],
                  pick_value(), 1'b0, '0);
    end
    send_item(ACT_QUERY, x, y, z, vox_t'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic wait_idle();
    vox_ch.valid <= 1'b0;
    while (expected_max_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_item();
    int ex, ey, ez;
    ex = extent(size_x_reg);
    ey = extent(size_y_reg);
    ez = extent(size_z_reg);
    if ($urandom_range(0, 99) < 45)
      send_item(ACT_WRITE, pick_pos(ex), pick_pos(ey), pick_pos(ez), pick_value(), 1'b0, '0);
    else
      query_prepared(pick_pos(ex), pick_pos(ey), pick_pos(ez));
  endtask

  initial begin : stimulus
    int random_start;
    int phase_end;
    stim_row_t row;
    vox_ch.valid       <= 1'b0;
    vox_ch.action      <= ACT_WRITE;
    vox_ch.pos_x       <= '0;
    vox_ch.pos_y       <= '0;
    vox_ch.pos_z       <= '0;
    vox_ch.voxel_value <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_SIZE_X;
    cfg_data_i         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_item(row.action, row.x, row.y, row.z, row.value, row.has_exp, row.exp_max);
      end
    end

    random_start = items_sent;
    for (int phase = 0; items_sent - random_start < RANDOM_ITEMS; phase++) begin
      wait_idle();
      if (phase == 0) begin
        write_reg(REG_SIZE_X, 6'd32);
        write_reg(REG_SIZE_Y, 6'd1);
        write_reg(REG_SIZE_Z, 6'd5);
      end else begin
        write_reg(REG_SIZE_X, pick_extent());
        write_reg(REG_SIZE_Y, pick_extent());
        write_reg(REG_SIZE_Z, pick_extent());
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_item();
    end

    wait_idle();
    if (error_count == 0) begin
      $display("[volume_neighbourhood_max_unit] OK");
    end else begin
      $display("[volume_neighbourhood_max_unit] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int   stall;
    int   taken;
    bit   long_hold_done;
    vox_t exp_max;
    taken = 0;
    long_hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // One long hold-off keeps a result waiting until a further query holds and the input stalls.
      if (!long_hold_done && taken == 40) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        stall = recv_calm ? 0 : $urandom_range(0, 5);
      end
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (res_ch.valid !== 1'b1);
      taken++;
      if (expected_max_q.size() == 0) begin
        $error("max_value: expected none, got %0h", res_ch.max_value);
        error_count++;
      end else begin
        exp_max = expected_max_q.pop_front();
        if (res_ch.max_value !== exp_max) begin
          $error("max_value: expected %0h, got %0h", exp_max, res_ch.max_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[volume_neighbourhood_max_unit] ERROR");
      $finish;
    end
  end

endmodule
